[rtl/core/rpq_pkg.sv]
// ----------------------------------------------------------------------------
// RGB332 perceptual quantizer package
// Shared types, constants, level tables and fixed-point Lab helpers.
// ----------------------------------------------------------------------------
package rpq_pkg;

  // Number of palette codes scanned, and fraction bits of the Lab values.
  localparam int CANDIDATES    = 256;
  localparam int LAB_FRAC_BITS = 7;

  localparam int LAB_SHIFT = 16 - LAB_FRAC_BITS;
  localparam int LAB_HALF  = 1 << (LAB_SHIFT - 1);
  localparam int IDX_W     = (CANDIDATES > 1) ? $clog2(CANDIDATES) : 1;

  localparam int LIN_W     = 17;
  localparam int ACC_W     = 30;
  localparam int DIV_NUM_W = 33;
  localparam int DIV_DEN_W = 17;
  localparam int QUO_W     = 17;
  localparam int RCP_W     = 20;
  localparam int PROD_W    = DIV_NUM_W + RCP_W;
  localparam int REM_W     = DIV_NUM_W + 1;
  localparam int SQ_W      = 33;
  localparam int DIST_W    = 35;
  localparam int CBRT_TOP  = 16;

  localparam int DEN_X    = 95047;
  localparam int DEN_Y    = 10000;
  localparam int DEN_Z    = 108883;
  localparam int RND_X    = 47523;
  localparam int RND_Y    = 5000;
  localparam int RND_Z    = 54441;
  localparam int CV_DEN   = 116000;
  localparam int CV_SLOPE = 7787 * 116;
  localparam int CV_OFS   = 16 * 65536 * 1000 + 58000;
  // v * 125000 > 72548352 holds exactly when v exceeds this knee.
  localparam int CURVE_KNEE = 72548352 / 125000;

  // Reciprocals scaled by 2^DIV_NUM_W and rounded down. For any numerator
  // below 2^DIV_NUM_W the product estimate is the quotient or one less.
  localparam logic [RCP_W-1:0] RCP_X  = RCP_W'((64'd1 << DIV_NUM_W) / 64'(DEN_X));
  localparam logic [RCP_W-1:0] RCP_Y  = RCP_W'((64'd1 << DIV_NUM_W) / 64'(DEN_Y));
  localparam logic [RCP_W-1:0] RCP_Z  = RCP_W'((64'd1 << DIV_NUM_W) / 64'(DEN_Z));
  localparam logic [RCP_W-1:0] RCP_CV = RCP_W'((64'd1 << DIV_NUM_W) / 64'(CV_DEN));

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_t;

  typedef struct packed {
    logic [7:0] palette_index;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } res_t;

  typedef struct packed {
    logic signed [15:0] l;
    logic signed [15:0] a;
    logic signed [15:0] b;
  } lab_t;

  typedef logic [255:0][LIN_W-1:0] lin_tab_t;
  typedef lab_t [255:0] pal_tab_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MAT, S_XDIV_GO, S_XDIV_WAIT, S_CV_SEL, S_CR_SQ, S_CR_CUBE,
    S_CV_WAIT, S_LAB, S_SCAN, S_DRAIN, S_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MAT, OP_XYZ_DIV, OP_XYZ_WAIT, OP_CV_SEL, OP_CV_SQ,
    OP_CV_CUBE, OP_CV_WAIT, OP_LAB, OP_SCAN, OP_OUT
  } dp_op_e;

  typedef enum logic [1:0] {
    DIV_X, DIV_Y, DIV_Z, DIV_CV
  } div_sel_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] ch;
    logic [1:0] k;
    logic [4:0] bitn;
    logic [7:0] idx;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic curve_big;
    logic scan_busy;
  } sts_t;

  function automatic logic [7:0] lvl3(input logic [2:0] c);
    logic [7:0] v;
    case (c)
      3'd0:    v = 8'h00;
      3'd1:    v = 8'h20;
      3'd2:    v = 8'h40;
      3'd3:    v = 8'h60;
      3'd4:    v = 8'h80;
      3'd5:    v = 8'hA0;
      3'd6:    v = 8'hC0;
      default: v = 8'hFF;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] lvl2(input logic [1:0] c);
    logic [7:0] v;
    case (c)
      2'd0:    v = 8'h00;
      2'd1:    v = 8'h60;
      2'd2:    v = 8'hA0;
      default: v = 8'hFF;
    endcase
    return v;
  endfunction

  function automatic logic cand_gray(input logic [7:0] i);
    return (lvl3(i[7:5]) == lvl3(i[4:2])) && (lvl3(i[7:5]) == lvl2(i[1:0]));
  endfunction

  // XYZ matrix weights: row ch (X, Y, Z), column k (R, G, B).
  function automatic logic [13:0] mat_coef(input logic [1:0] ch, input logic [1:0] k);
    logic [13:0] c;
    case ({ch, k})
      4'b00_00: c = 14'd4124;
      4'b00_01: c = 14'd3576;
      4'b00_10: c = 14'd1805;
      4'b01_00: c = 14'd2126;
      4'b01_01: c = 14'd7152;
      4'b01_10: c = 14'd722;
      4'b10_00: c = 14'd193;
      4'b10_01: c = 14'd1192;
      4'b10_10: c = 14'd9505;
      default:  c = 14'd0;
    endcase
    return c;
  endfunction

  // Q16 to Lab fixed point: round half up, then saturate to 16 bits.
  function automatic logic signed [15:0] to_lab(input logic signed [27:0] v);
    logic signed [27:0] n;
    logic signed [27:0] q;
    logic signed [15:0] r;
    n = v + 28'(LAB_HALF);
    q = n >>> LAB_SHIFT;
    if (q > 28'sd32767) begin
      r = 16'sh7FFF;
    end else if (q < -28'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

  function automatic lab_t lab_from_f(input logic [16:0] fx, input logic [16:0] fy,
                                      input logic [16:0] fz);
    logic signed [27:0] sx, sy, sz, lv, av, bv;
    lab_t o;
    sx = signed'({11'b0, fx});
    sy = signed'({11'b0, fy});
    sz = signed'({11'b0, fz});
    lv = sy * 28'sd116 - 28'sd1048576;
    av = (sx - sy) * 28'sd500;
    bv = (sy - sz) * 28'sd200;
    o.l = to_lab(lv);
    o.a = to_lab(av);
    o.b = to_lab(bv);
    return o;
  endfunction

  // The functions below only build constant tables at elaboration.
  function automatic logic [63:0] mul30(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] pow5(input logic [63:0] r);
    logic [63:0] r2, r4;
    r2 = mul30(r, r);
    r4 = mul30(r2, r2);
    return mul30(r4, r);
  endfunction

  function automatic logic [LIN_W-1:0] lin_of(input logic [63:0] c);
    logic [63:0] one, t, t2, root, cand, res;
    one  = 64'd1 << 30;
    root = '0;
    if (c <= 64'd10) begin
      res = (c * 64'd6553600 + 64'd164730) / 64'd329460;
      return res[LIN_W-1:0];
    end
    t = (((c * 64'd1000 + 64'd14025) << 30) + 64'd134512) / 64'd269025;
    if (t > one) t = one;
    t2 = mul30(t, t);
    for (int bn = 30; bn >= 0; bn--) begin
      cand = root | (64'd1 << bn);
      if (cand <= one && pow5(cand) <= t2) root = cand;
    end
    res = (mul30(t2, root) + (64'd1 << 13)) >> 14;
    return res[LIN_W-1:0];
  endfunction

  function automatic logic [16:0] curve_const(input logic [63:0] v);
    logic [63:0] f, cand, q;
    f = '0;
    if (v > 64'(CURVE_KNEE)) begin
      for (int bn = CBRT_TOP; bn >= 0; bn--) begin
        cand = f | (64'd1 << bn);
        if (cand * cand * cand <= (v << 32)) f = cand;
      end
      return f[16:0];
    end
    q = (v * 64'(CV_SLOPE) + 64'(CV_OFS)) / 64'(CV_DEN);
    return q[16:0];
  endfunction

  function automatic lin_tab_t build_lin();
    lin_tab_t t;
    for (int i = 0; i < 256; i++) t[i] = lin_of(64'(i));
    return t;
  endfunction

  function automatic pal_tab_t build_pal(input lin_tab_t lin);
    pal_tab_t p;
    logic [63:0] lr, lg, lb, xn, yn, zn;
    logic [7:0] i8;
    for (int i = 0; i < 256; i++) begin
      i8 = 8'(i);
      lr = 64'(lin[lvl3(i8[7:5])]);
      lg = 64'(lin[lvl3(i8[4:2])]);
      lb = 64'(lin[lvl2(i8[1:0])]);
      xn = ((64'(mat_coef(2'd0, 2'd0)) * lr + 64'(mat_coef(2'd0, 2'd1)) * lg
            + 64'(mat_coef(2'd0, 2'd2)) * lb) * 64'd10 + 64'(RND_X)) / 64'(DEN_X);
      yn = (64'(mat_coef(2'd1, 2'd0)) * lr + 64'(mat_coef(2'd1, 2'd1)) * lg
            + 64'(mat_coef(2'd1, 2'd2)) * lb + 64'(RND_Y)) / 64'(DEN_Y);
      zn = ((64'(mat_coef(2'd2, 2'd0)) * lr + 64'(mat_coef(2'd2, 2'd1)) * lg
            + 64'(mat_coef(2'd2, 2'd2)) * lb) * 64'd10 + 64'(RND_Z)) / 64'(DEN_Z);
      p[i] = lab_from_f(curve_const(xn), curve_const(yn), curve_const(zn));
    end
    return p;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin();
  localparam pal_tab_t PAL_LAB = build_pal(LIN_TAB);

endpackage

[rtl/core/rpq_div.sv]
// ----------------------------------------------------------------------------
// RPQ divider
// Division by one of the fixed conversion denominators: a reciprocal product
// gives the quotient or one less, and one compare on the remainder corrects it.
// ----------------------------------------------------------------------------
module rpq_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rpq_pkg::DIV_NUM_W-1:0] num_i,
  input  rpq_pkg::div_sel_e             sel_i,
  output logic                          done_o,
  output logic [rpq_pkg::QUO_W-1:0]     quo_o
);
  import rpq_pkg::*;

  logic                 run_q, est_vld_q, done_q;
  logic [DIV_NUM_W-1:0] num_q;
  div_sel_e             sel_q;
  logic [QUO_W-1:0]     est_q, quo_q;
  logic [RCP_W-1:0]     rcp;
  logic [DIV_DEN_W-1:0] den;
  logic [PROD_W-1:0]    prod;
  logic [REM_W-1:0]     back, rem;

  always_comb begin
    case (sel_q)
      DIV_X: begin
        rcp = RCP_X;
        den = DIV_DEN_W'(DEN_X);
      end
      DIV_Y: begin
        rcp = RCP_Y;
        den = DIV_DEN_W'(DEN_Y);
      end
      DIV_Z: begin
        rcp = RCP_Z;
        den = DIV_DEN_W'(DEN_Z);
      end
      default: begin
        rcp = RCP_CV;
        den = DIV_DEN_W'(CV_DEN);
      end
    endcase
  end

  // The quotients of this block stay below 2^QUO_W, so the upper product
  // bits are always zero.
  assign prod = PROD_W'(num_q) * PROD_W'(rcp);
  assign back = REM_W'(est_q) * REM_W'(den);
  assign rem  = {1'b0, num_q} - back;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      est_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      run_q     <= start_i;
      est_vld_q <= run_q;
      done_q    <= est_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      sel_q <= sel_i;
    end
    if (run_q) begin
      est_q <= prod[DIV_NUM_W +: QUO_W];
    end
    if (est_vld_q) begin
      quo_q <= est_q + QUO_W'(rem >= REM_W'(den));
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[rtl/core/rpq_dp.sv]
// ----------------------------------------------------------------------------
// RPQ datapath
// Pixel to Lab conversion, candidate distance pipeline and best-match store.
// ----------------------------------------------------------------------------
module rpq_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rpq_pkg::pix_t pix_i,
  input  rpq_pkg::cmd_t cmd_i,
  output rpq_pkg::sts_t sts_o,
  output rpq_pkg::res_t res_o
);
  import rpq_pkg::*;

  logic [LIN_W-1:0]     lin_q [3];
  logic [16:0]          xyz_q [3];
  logic [16:0]          f_q   [3];
  logic                 gray_q;
  logic [ACC_W-1:0]     acc_q;
  logic [33:0]          sq_q;
  lab_t                 lab_q;

  logic                 s1_valid_q, s2_valid_q;
  logic [7:0]           s1_idx_q, s2_idx_q;
  logic                 s1_ok_q, s2_ok_q;
  logic signed [16:0]   s1_dl_q, s1_da_q, s1_db_q;
  logic [SQ_W-1:0]      s2_ql_q, s2_qa_q, s2_qb_q;
  logic                 found_q;
  logic [DIST_W-1:0]    best_q;
  logic [7:0]           pick_q;
  res_t                 res_q;

  // Input gray class.
  logic [7:0]  mx, mn;
  logic [11:0] spread10;
  logic        in_gray;

  always_comb begin
    mx = (pix_i.red_in > pix_i.green_in) ? pix_i.red_in : pix_i.green_in;
    mx = (mx > pix_i.blue_in) ? mx : pix_i.blue_in;
    mn = (pix_i.red_in < pix_i.green_in) ? pix_i.red_in : pix_i.green_in;
    mn = (mn < pix_i.blue_in) ? mn : pix_i.blue_in;
    spread10 = 12'(mx - mn) * 12'd10;
    in_gray  = (mx == 8'd0) || (spread10 < {4'b0, mx});
  end

  // Divider operand selection.
  logic                 div_start, div_done, big;
  logic [DIV_NUM_W-1:0] div_num;
  logic [QUO_W-1:0]     div_quo;
  div_sel_e             div_sel;
  logic [16:0]          v_cur;

  assign v_cur = xyz_q[cmd_i.ch];
  assign big   = v_cur > 17'(CURVE_KNEE);

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_sel   = DIV_CV;
    case (cmd_i.op)
      OP_XYZ_DIV: begin
        div_start = 1'b1;
        case (cmd_i.ch)
          2'd0: begin
            div_num = DIV_NUM_W'(acc_q) * DIV_NUM_W'(10) + DIV_NUM_W'(RND_X);
            div_sel = DIV_X;
          end
          2'd1: begin
            div_num = DIV_NUM_W'(acc_q) + DIV_NUM_W'(RND_Y);
            div_sel = DIV_Y;
          end
          default: begin
            div_num = DIV_NUM_W'(acc_q) * DIV_NUM_W'(10) + DIV_NUM_W'(RND_Z);
            div_sel = DIV_Z;
          end
        endcase
      end
      OP_CV_SEL: begin
        div_start = !big;
        div_num   = DIV_NUM_W'(v_cur[9:0]) * DIV_NUM_W'(CV_SLOPE) + DIV_NUM_W'(CV_OFS);
      end
      default: ;
    endcase
  end

  rpq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .sel_i  (div_sel),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Cube root search step.
  logic [16:0] cand;
  logic [50:0] cube;

  assign cand = f_q[cmd_i.ch] | (17'd1 << cmd_i.bitn);
  assign cube = 51'(sq_q * cand);

  // Candidate distance terms.
  lab_t               pal;
  logic signed [33:0] pl, pa, pb;
  logic [DIST_W-1:0]  dsum;

  assign pal  = PAL_LAB[cmd_i.idx];
  assign pl   = s1_dl_q * s1_dl_q;
  assign pa   = s1_da_q * s1_da_q;
  assign pb   = s1_db_q * s1_db_q;
  assign dsum = DIST_W'(s2_ql_q) + DIST_W'(s2_qa_q) + DIST_W'(s2_qb_q);

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        lin_q[0] <= LIN_TAB[pix_i.red_in];
        lin_q[1] <= LIN_TAB[pix_i.green_in];
        lin_q[2] <= LIN_TAB[pix_i.blue_in];
        gray_q   <= in_gray;
        pick_q   <= '0;
      end
      OP_MAT: begin
        acc_q <= ((cmd_i.k == 2'd0) ? '0 : acc_q)
               + ACC_W'(mat_coef(cmd_i.ch, cmd_i.k) * lin_q[cmd_i.k]);
      end
      OP_XYZ_WAIT: begin
        if (div_done) xyz_q[cmd_i.ch] <= div_quo;
      end
      OP_CV_SEL:  f_q[cmd_i.ch] <= '0;
      OP_CV_SQ:   sq_q <= 34'(cand * cand);
      OP_CV_CUBE: begin
        if (cube <= {2'b0, xyz_q[cmd_i.ch], 32'b0}) f_q[cmd_i.ch] <= cand;
      end
      OP_CV_WAIT: begin
        if (div_done) f_q[cmd_i.ch] <= div_quo;
      end
      OP_LAB: lab_q <= lab_from_f(f_q[0], f_q[1], f_q[2]);
      OP_OUT: begin
        res_q.palette_index <= pick_q;
        res_q.red_out       <= lvl3(pick_q[7:5]);
        res_q.green_out     <= lvl3(pick_q[4:2]);
        res_q.blue_out      <= lvl2(pick_q[1:0]);
      end
      default: ;
    endcase

    s1_idx_q <= cmd_i.idx;
    s1_ok_q  <= cand_gray(cmd_i.idx) == gray_q;
    s1_dl_q  <= {lab_q.l[15], lab_q.l} - {pal.l[15], pal.l};
    s1_da_q  <= {lab_q.a[15], lab_q.a} - {pal.a[15], pal.a};
    s1_db_q  <= {lab_q.b[15], lab_q.b} - {pal.b[15], pal.b};
    s2_idx_q <= s1_idx_q;
    s2_ok_q  <= s1_ok_q;
    s2_ql_q  <= pl[SQ_W-1:0];
    s2_qa_q  <= pa[SQ_W-1:0];
    s2_qb_q  <= pb[SQ_W-1:0];

    // Strict less-than keeps the earliest code among equal distances.
    if (s2_valid_q && s2_ok_q && (!found_q || dsum < best_q)) begin
      best_q <= dsum;
      pick_q <= s2_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      found_q    <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.op == OP_SCAN;
      s2_valid_q <= s1_valid_q;
      if (cmd_i.op == OP_LOAD) begin
        found_q <= 1'b0;
      end else if (s2_valid_q && s2_ok_q) begin
        found_q <= 1'b1;
      end
    end
  end

  assign sts_o.div_done  = div_done;
  assign sts_o.curve_big = big;
  assign sts_o.scan_busy = s1_valid_q | s2_valid_q;
  assign res_o           = res_q;

endmodule

[rtl/core/rpq_ctrl.sv]
// ----------------------------------------------------------------------------
// RPQ controller
// Sequences conversion, candidate scan and the output handshake.
// ----------------------------------------------------------------------------
module rpq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  rpq_pkg::sts_t sts_i,
  output rpq_pkg::cmd_t cmd_o
);
  import rpq_pkg::*;

  state_e           state_q, state_d;
  logic [1:0]       ch_q, ch_d, k_q, k_d;
  logic [4:0]       bit_q, bit_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and counters.
  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    k_d     = k_q;
    bit_d   = bit_q;
    idx_d   = idx_q;
    case (state_q)
      S_IDLE: begin
        ch_d = 2'd0;
        k_d  = 2'd0;
        if (in_valid_i) state_d = S_MAT;
      end
      S_MAT: begin
        k_d = k_q + 2'd1;
        if (k_q == 2'd2) state_d = S_XDIV_GO;
      end
      S_XDIV_GO: state_d = S_XDIV_WAIT;
      S_XDIV_WAIT: begin
        if (sts_i.div_done) begin
          k_d = 2'd0;
          if (ch_q == 2'd2) begin
            ch_d    = 2'd0;
            state_d = S_CV_SEL;
          end else begin
            ch_d    = ch_q + 2'd1;
            state_d = S_MAT;
          end
        end
      end
      S_CV_SEL: begin
        bit_d   = 5'(CBRT_TOP);
        state_d = sts_i.curve_big ? S_CR_SQ : S_CV_WAIT;
      end
      S_CR_SQ: state_d = S_CR_CUBE;
      S_CR_CUBE: begin
        if (bit_q == 5'd0) begin
          ch_d    = ch_q + 2'd1;
          state_d = (ch_q == 2'd2) ? S_LAB : S_CV_SEL;
        end else begin
          bit_d   = bit_q - 5'd1;
          state_d = S_CR_SQ;
        end
      end
      S_CV_WAIT: begin
        if (sts_i.div_done) begin
          ch_d    = ch_q + 2'd1;
          state_d = (ch_q == 2'd2) ? S_LAB : S_CV_SEL;
        end
      end
      S_LAB: begin
        idx_d   = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == IDX_W'(CANDIDATES - 1)) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts_i.scan_busy) state_d = S_DONE;
      end
      S_DONE: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o.op   = OP_NONE;
    cmd_o.ch   = ch_q;
    cmd_o.k    = k_q;
    cmd_o.bitn = bit_q;
    cmd_o.idx  = 8'(idx_q);
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_MAT:       cmd_o.op = OP_MAT;
      S_XDIV_GO:   cmd_o.op = OP_XYZ_DIV;
      S_XDIV_WAIT: cmd_o.op = OP_XYZ_WAIT;
      S_CV_SEL:    cmd_o.op = OP_CV_SEL;
      S_CR_SQ:     cmd_o.op = OP_CV_SQ;
      S_CR_CUBE:   cmd_o.op = OP_CV_CUBE;
      S_CV_WAIT:   cmd_o.op = OP_CV_WAIT;
      S_LAB:       cmd_o.op = OP_LAB;
      S_SCAN:      cmd_o.op = OP_SCAN;
      S_DONE: begin
        if (slot_free) cmd_o.op = OP_OUT;
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || (state_q == S_DONE && slot_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= '0;
      k_q         <= '0;
      bit_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      k_q         <= k_d;
      bit_q       <= bit_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_MAT)
    else $error("accepted pixel did not start the conversion");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == S_XDIV_WAIT || state_q == S_CV_WAIT))
    else $error("divider finished outside a wait state");

  a_result_posted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && slot_free |=> out_valid_q)
    else $error("finished result was not presented");
`endif

endmodule

[rtl/core/rgb332_perceptual_quantizer_top.sv]
// ----------------------------------------------------------------------------
// RGB332 perceptual quantizer
// Maps a 24-bit RGB pixel to the CIE76-nearest RGB332 code of its grey class.
// ----------------------------------------------------------------------------
// Usage: a pixel is presented on in_data_i with in_valid_i and is taken in a
// transfer when in_ready_o is high. One result (code and expanded levels)
// leaves on out_data_o with out_valid_o/out_ready_i. The pixel goes to Lab in
// fixed point: a three-step matrix sum and a constant divide (reciprocal
// product, then one correction) per XYZ channel, then per channel either a
// 17-step cube root search (each step a square, then a cube and compare) or
// another constant divide. The 256 candidates are then scanned one per cycle
// through a three-stage distance pipeline against a constant Lab table. The
// time from transfer to result depends on how many channels need the cube
// root search. One pixel is worked on at a time: a new pixel is taken only
// once the previous result has entered the output register. The result sits
// in that register, so a new pixel is taken while the previous result still
// waits; when the receiver stalls, a finished result is held until the
// register frees. Reset clears all control state; the tables are constants
// and need no start-up pass.
// ----------------------------------------------------------------------------
module rgb332_perceptual_quantizer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rpq_pkg::pix_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rpq_pkg::res_t out_data_o
);
  import rpq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rpq_dp u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (in_data_i),
    .cmd_i (cmd),
    .sts_o (sts),
    .res_o (out_data_o)
  );

endmodule

[test/rgb332_perceptual_quantizer_top_test.sv]
// ----------------------------------------------------------------------------
// RGB332 perceptual quantizer testbench
// Pixels are sent through the valid/ready input channel. For each accepted
// pixel an independent fixed-point predictor works out the nearest palette
// code. Results are checked field by field, in order, while both sides idle
// and stall at random.
// ----------------------------------------------------------------------------
module rgb332_perceptual_quantizer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rpq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 600;
  localparam int unsigned HOLD_OFF_CYCLES = 3000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  pix_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  res_t out_data_o;

  rgb332_perceptual_quantizer_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_off_req;
  res_t        nearest_q[$];

  bit [16:0]   linear_lut[256];
  lab_t        palette_lab[256];

  // ------------------------------------------------------------------------
  // Colour predictor
  // ------------------------------------------------------------------------
  function automatic longint unsigned q30_product(longint unsigned a, longint unsigned b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint unsigned q30_fifth(longint unsigned r);
    longint unsigned sq;
    longint unsigned quad;
    sq   = q30_product(r, r);
    quad = q30_product(sq, sq);
    return q30_product(quad, r);
  endfunction

  function automatic bit [16:0] linearise(int unsigned code);
    longint unsigned unity;
    longint unsigned t;
    longint unsigned t_sq;
    longint unsigned root;
    longint unsigned trial;
    unity = 64'd1 << 30;
    root  = 0;
    if (code <= 10) return 17'((longint'(code) * 6553600 + 164730) / 329460);
    t = (((longint'(code) * 1000 + 14025) << 30) + 134512) / 269025;
    if (t > unity) t = unity;
    t_sq = q30_product(t, t);
    // Fifth root of t squared gives t to the power 2.4 after one more product.
    for (int bn = 30; bn >= 0; bn--) begin
      trial = root | (64'd1 << bn);
      if (trial <= unity && q30_fifth(trial) <= t_sq) root = trial;
    end
    return 17'((q30_product(t_sq, root) + (64'd1 << 13)) >> 14);
  endfunction

  function automatic longint cie_curve(longint unsigned v);
    longint unsigned f;
    longint unsigned trial;
    f = 0;
    if (v * 125000 > 72548352) begin
      for (int bn = 16; bn >= 0; bn--) begin
        trial = f | (64'd1 << bn);
        if (trial * trial * trial <= (v << 32)) f = trial;
      end
      return longint'(f);
    end
    return longint'((v * 7787 * 116 + 16 * 65536 * 1000 + 58000) / 116000);
  endfunction

  function automatic logic signed [15:0] lab_round(longint v);
    longint step_sz;
    longint n;
    longint q;
    step_sz = longint'(1) << (16 - LAB_FRAC_BITS);
    n = v + step_sz / 2;
    q = (n >= 0) ? n / step_sz : -((-n + step_sz - 1) / step_sz);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  function automatic lab_t rgb_to_lab(bit [7:0] r, bit [7:0] g, bit [7:0] b);
    longint unsigned lr, lg, lb, xn, yn, zn;
    longint fx, fy, fz;
    lab_t o;
    lr = linear_lut[r];
    lg = linear_lut[g];
    lb = linear_lut[b];
    xn = ((4124 * lr + 3576 * lg + 1805 * lb) * 10 + 47523) / 95047;
    yn = (2126 * lr + 7152 * lg + 722 * lb + 5000) / 10000;
    zn = ((193 * lr + 1192 * lg + 9505 * lb) * 10 + 54441) / 108883;
    fx = cie_curve(xn);
    fy = cie_curve(yn);
    fz = cie_curve(zn);
    o.l = lab_round(116 * fy - 16 * 65536);
    o.a = lab_round(500 * (fx - fy));
    o.b = lab_round(200 * (fy - fz));
    return o;
  endfunction

  function automatic bit [7:0] level3(bit [2:0] c);
    bit [7:0] steps[8] = '{8'h00, 8'h20, 8'h40, 8'h60, 8'h80, 8'hA0, 8'hC0, 8'hFF};
    return steps[c];
  endfunction

  function automatic bit [7:0] level2(bit [1:0] c);
    bit [7:0] steps[4] = '{8'h00, 8'h60, 8'hA0, 8'hFF};
    return steps[c];
  endfunction

  function automatic res_t nearest_code(pix_t px);
    bit [7:0] hi, lo, cr, cg, cb, pick;
    bit pix_gray, code_gray, found;
    longint dl, da, db;
    longint unsigned sq_dist, best;
    lab_t p;
    res_t o;
    hi = px.red_in;
    if (px.green_in > hi) hi = px.green_in;
    if (px.blue_in > hi) hi = px.blue_in;
    lo = px.red_in;
    if (px.green_in < lo) lo = px.green_in;
    if (px.blue_in < lo) lo = px.blue_in;
    pix_gray = (hi == 0) || (10 * (int'(hi) - int'(lo)) < int'(hi));
    p = rgb_to_lab(px.red_in, px.green_in, px.blue_in);
    found = 0;
    best = 0;
    pick = 0;
    for (int i = 0; i < CANDIDATES && i < 256; i++) begin
      cr = level3(i[7:5]);
      cg = level3(i[4:2]);
      cb = level2(i[1:0]);
      code_gray = (cr == cg) && (cr == cb);
      dl = longint'(p.l) - longint'(palette_lab[i].l);
      da = longint'(p.a) - longint'(palette_lab[i].a);
      db = longint'(p.b) - longint'(palette_lab[i].b);
      sq_dist = dl * dl + da * da + db * db;
      if (code_gray == pix_gray && (!found || sq_dist < best)) begin
        found = 1;
        best = sq_dist;
        pick = 8'(i);
      end
    end
    o.palette_index = pick;
    o.red_out = level3(pick[7:5]);
    o.green_out = level3(pick[4:2]);
    o.blue_out = level2(pick[1:0]);
    return o;
  endfunction

  // ------------------------------------------------------------------------
  // Clock, cycle limit, receiver and result checking
  // ------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rgb332_perceptual_quantizer_top regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req != 0) begin
        hold_left = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left != 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (nearest_q.size() == 0) begin
        $error("result with no pixel outstanding: %h", out_data_o);
        fail_count++;
      end else begin
        want = nearest_q.pop_front();
        if (out_data_o.palette_index !== want.palette_index) begin
          $error("palette_index: expected %0d, got %0d", want.palette_index,
                 out_data_o.palette_index);
          fail_count++;
        end
        if (out_data_o.red_out !== want.red_out) begin
          $error("red_out: expected %h, got %h", want.red_out, out_data_o.red_out);
          fail_count++;
        end
        if (out_data_o.green_out !== want.green_out) begin
          $error("green_out: expected %h, got %h", want.green_out, out_data_o.green_out);
          fail_count++;
        end
        if (out_data_o.blue_out !== want.blue_out) begin
          $error("blue_out: expected %h, got %h", want.blue_out, out_data_o.blue_out);
          fail_count++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------
  // Entered and left at a falling edge; valid stays high between
  // back-to-back pixels.
  task automatic send_pixel(bit [7:0] r, bit [7:0] g, bit [7:0] b);
    pix_t px;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    px.red_in = r;
    px.green_in = g;
    px.blue_in = b;
    in_valid_i = 1'b1;
    in_data_i = px;
    do @(posedge clk_i); while (!in_ready_o);
    nearest_q = {nearest_q, nearest_code(px)};
    @(negedge clk_i);
  endtask

  task automatic wait_results;
    in_valid_i = 1'b0;
    while (nearest_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_random_pixel;
    bit [7:0] base;
    case ($urandom_range(3))
      0: send_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
      1: begin
        // Near-grey pixels probe the grey classification boundary.
        base = $urandom_range(255);
        send_pixel(base, 8'(base + $urandom_range(6) - 3),
                   8'(base - $urandom_range(base / 8 + 1)));
      end
      2: send_pixel($urandom_range(12), $urandom_range(12), $urandom_range(12));
      default: begin
        base = $urandom_range(255);
        send_pixel(base, base, base);
      end
    endcase
  endtask

  task automatic test_directed;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'h01, 8'h00, 8'h00);
    send_pixel(8'd10, 8'd10, 8'd10);
    send_pixel(8'd11, 8'd11, 8'd11);
    send_pixel(8'd10, 8'd11, 8'd9);
    send_pixel(8'd100, 8'd91, 8'd95);
    send_pixel(8'd100, 8'd90, 8'd95);
    send_pixel(8'd255, 8'd230, 8'd240);
    send_pixel(8'd255, 8'd229, 8'd240);
    send_pixel(8'hA0, 8'h60, 8'hFF);
    send_pixel(8'h20, 8'hC0, 8'h60);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_pixel(8'h55, 8'hAA, 8'h55);
    send_pixel(8'hFE, 8'hFF, 8'hFE);
    send_pixel(8'h80, 8'h80, 8'h80);
    send_pixel(8'h7F, 8'h00, 8'hFF);
    wait_results();
  endtask

  task automatic test_random(int unsigned n, int unsigned idle, int unsigned stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_random_pixel();
    wait_results();
  endtask

  // The receiver holds off while pixels keep coming, so the output register
  // and the working pixel fill up and the input stalls.
  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = HOLD_OFF_CYCLES;
    repeat (6) send_random_pixel();
    wait_results();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cycle_count = 0;
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_req = 0;
    for (int i = 0; i < 256; i++) linear_lut[i] = linearise(i);
    for (int i = 0; i < 256; i++) begin
      palette_lab[i] = rgb_to_lab(level3(i[7:5]), level3(i[4:2]), level2(i[1:0]));
    end
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random(180, 0, 0);
    test_random(170, 52, 0);
    test_random(170, 0, 52);
    test_random(170, 21, 21);
    test_backpressure();

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (nearest_q.size() != 0) begin
      $error("%0d results never arrived", nearest_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("rgb332_perceptual_quantizer_top regression: pass");
    end else begin
      $display("rgb332_perceptual_quantizer_top regression: fail");
    end
    $finish;
  end

endmodule
